// ----- sv/numeric_literal_scanner_core_assert.svh -----
// Assertion macros for the numeric literal scanner core.
// Used by the top level only; needs i_clk and i_rst_n in the including scope.
`ifndef NUMERIC_LITERAL_SCANNER_CORE_ASSERT_SVH
`define NUMERIC_LITERAL_SCANNER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define NLSC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that, once seen, implies another one at the next edge.
`define NLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/nls_pkg.sv -----
// Shared types and constants for the numeric literal scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package nls_pkg;

    localparam int MAX_INT_SPELLING = 255;
    localparam int LENGTH_BITS      = 16;
    localparam int VALUE_BITS       = 63;
    localparam int PROD_BITS        = VALUE_BITS + 4;
    localparam int SPELL_BITS       = $clog2(MAX_INT_SPELLING + 2);
    localparam int CNT_BITS         = (LENGTH_BITS > SPELL_BITS) ? LENGTH_BITS : SPELL_BITS;

    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [9:0] {
        M_IDLE     = 10'b00_0000_0001,
        M_ZERO     = 10'b00_0000_0010,
        M_INT      = 10'b00_0000_0100,
        M_DOT      = 10'b00_0000_1000,
        M_FRAC     = 10'b00_0001_0000,
        M_EXP_E    = 10'b00_0010_0000,
        M_EXP_SIGN = 10'b00_0100_0000,
        M_EXP      = 10'b00_1000_0000,
        M_BIN      = 10'b01_0000_0000,
        M_HEX      = 10'b10_0000_0000
    } t_scan_mode;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic       is_dec;
        logic       is_bin;
        logic       is_hex;
        logic [3:0] digit;
        logic       is_us;
        logic       is_dot;
        logic       is_e;
        logic       is_sign;
        logic       is_b;
        logic       is_x;
    } t_byte_class;

    typedef struct packed {
        logic [1:0]             kind;
        logic [VALUE_BITS-1:0]  value;
        logic [LENGTH_BITS-1:0] length;
        logic [1:0]             replay;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/nls_classify.sv -----
// Byte classifier: decodes one source byte into character classes and a digit value.
// Depends on nls_pkg.
`default_nettype none

module nls_classify (
    input  wire logic [7:0]         i_byte,
    output nls_pkg::t_byte_class    o_class
);
    import nls_pkg::*;

    logic       w_dec;
    logic       w_lhex;
    logic       w_uhex;
    logic [7:0] w_dec_val;
    logic [7:0] w_lhex_val;
    logic [7:0] w_uhex_val;

    always_comb begin
        w_dec      = (i_byte >= CH_0) && (i_byte <= CH_9);
        w_lhex     = (i_byte >= CH_LA) && (i_byte <= CH_LF);
        w_uhex     = (i_byte >= CH_UA) && (i_byte <= CH_UF);
        w_dec_val  = i_byte - CH_0;
        w_lhex_val = i_byte - CH_LA + 8'd10;
        w_uhex_val = i_byte - CH_UA + 8'd10;

        o_class.is_dec  = w_dec;
        o_class.is_bin  = (i_byte == CH_0) || (i_byte == CH_1);
        o_class.is_hex  = w_dec || w_lhex || w_uhex;
        o_class.is_us   = (i_byte == CH_US);
        o_class.is_dot  = (i_byte == CH_DOT);
        o_class.is_e    = (i_byte == CH_LE) || (i_byte == CH_UE);
        o_class.is_sign = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
        o_class.is_b    = (i_byte == CH_LB);
        o_class.is_x    = (i_byte == CH_LX);
        if (w_dec) begin
            o_class.digit = w_dec_val[3:0];
        end else if (w_lhex) begin
            o_class.digit = w_lhex_val[3:0];
        end else begin
            o_class.digit = w_uhex_val[3:0];
        end
    end

endmodule

`default_nettype wire

// ----- sv/nls_scan.sv -----
// Scanner state machine: holds the literal state, updates it for one byte per step
// and forms the result when the literal ends or its first byte is rejected. Depends on nls_pkg.
`default_nettype none

module nls_scan (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_end_of_text,
    input  wire nls_pkg::t_byte_class   i_class,
    output logic                        o_emit,
    output nls_pkg::t_result            o_result
);
    import nls_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    t_scan_mode              r_mode, n_mode;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic                    r_ovf, n_ovf;
    logic                    r_serr, n_serr;
    logic                    r_psep, n_psep;
    logic                    r_pdig, n_pdig;
    logic                    r_pfx, n_pfx;
    logic                    r_float, n_float;
    logic [CNT_BITS-1:0]     r_len, n_len;
    logic [1:0]              r_pend, n_pend;

    logic [1:0]              w_len_add;
    logic [CNT_BITS-1:0]     w_len_base;
    logic [CNT_BITS:0]       w_len_sum;
    logic                    w_do_acc;
    t_radix                  w_radix;
    logic                    w_fin;
    logic [1:0]              w_fin_replay;
    logic                    w_bad_first;
    logic [PROD_BITS-1:0]    w_acc_ext;
    logic [PROD_BITS-1:0]    w_prod;
    logic                    w_prod_ovf;
    logic                    w_sep_bad;
    logic                    w_int_bad;
    logic [LENGTH_BITS-1:0]  w_len_out;

    // Constant-base multiply-add for the integer value; the digit comes from the classifier.
    always_comb begin
        w_acc_ext = PROD_BITS'(r_acc);
        unique case (w_radix)
            RADIX_BIN: w_prod = (w_acc_ext << 1) + PROD_BITS'(i_class.digit);
            RADIX_HEX: w_prod = (w_acc_ext << 4) + PROD_BITS'(i_class.digit);
            default:   w_prod = (w_acc_ext << 3) + (w_acc_ext << 1)
                                + PROD_BITS'(i_class.digit);
        endcase
        w_prod_ovf = |w_prod[PROD_BITS-1:VALUE_BITS];
    end

    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_ovf        = r_ovf;
        n_serr       = r_serr;
        n_psep       = r_psep;
        n_pdig       = r_pdig;
        n_pfx        = r_pfx;
        n_float      = r_float;
        n_pend       = r_pend;
        w_len_add    = 2'd0;
        w_len_base   = r_len;
        w_do_acc     = 1'b0;
        w_radix      = RADIX_DEC;
        w_fin        = 1'b0;
        w_fin_replay = 2'd0;
        w_bad_first  = 1'b0;

        if (i_step) begin
            if (i_end_of_text) begin
                if (r_mode != M_IDLE) begin
                    w_fin        = 1'b1;
                    w_fin_replay = r_pend;
                end
            end else begin
                unique case (r_mode)
                    M_ZERO, M_INT: begin
                        if ((r_mode == M_ZERO) && (i_class.is_b || i_class.is_x)) begin
                            if (n_psep) n_serr = 1'b1;
                            w_len_add = w_len_add + 2'd1;
                            n_psep    = 1'b0;
                            n_pdig    = 1'b0;
                            n_mode    = i_class.is_b ? M_BIN : M_HEX;
                        end else begin
                            n_mode = M_INT;
                            if (i_class.is_dec) begin
                                w_len_add = w_len_add + 2'd1;
                                n_psep    = 1'b0;
                                n_pdig    = 1'b1;
                                w_do_acc  = 1'b1;
                                w_radix   = RADIX_DEC;
                            end else if (i_class.is_us) begin
                                if (!n_pdig) n_serr = 1'b1;
                                w_len_add = w_len_add + 2'd1;
                                n_psep    = 1'b1;
                                n_pdig    = 1'b0;
                            end else if (i_class.is_dot) begin
                                n_mode = M_DOT;
                                n_pend = 2'd1;
                            end else if (i_class.is_e) begin
                                n_mode = M_EXP_E;
                                n_pend = 2'd1;
                            end else begin
                                w_fin        = 1'b1;
                                w_fin_replay = 2'd1;
                            end
                        end
                    end
                    M_DOT: begin
                        if (i_class.is_dec) begin
                            if (n_psep) n_serr = 1'b1;
                            w_len_add = 2'd2;
                            n_psep    = 1'b0;
                            n_pdig    = 1'b1;
                            n_float   = 1'b1;
                            n_pend    = 2'd0;
                            n_mode    = M_FRAC;
                        end else begin
                            w_fin        = 1'b1;
                            w_fin_replay = 2'd2;
                        end
                    end
                    M_FRAC, M_EXP: begin
                        if (i_class.is_dec) begin
                            w_len_add = 2'd1;
                            n_psep    = 1'b0;
                            n_pdig    = 1'b1;
                        end else if (i_class.is_us) begin
                            if (!n_pdig) n_serr = 1'b1;
                            w_len_add = 2'd1;
                            n_psep    = 1'b1;
                            n_pdig    = 1'b0;
                        end else if ((r_mode == M_FRAC) && i_class.is_e) begin
                            n_mode = M_EXP_E;
                            n_pend = 2'd1;
                        end else begin
                            w_fin        = 1'b1;
                            w_fin_replay = 2'd1;
                        end
                    end
                    M_EXP_E, M_EXP_SIGN: begin
                        if ((r_mode == M_EXP_E) && i_class.is_sign) begin
                            n_mode = M_EXP_SIGN;
                            n_pend = 2'd2;
                        end else if (i_class.is_dec) begin
                            // The 'e', an optional sign and the digit all join the literal.
                            if (n_psep) n_serr = 1'b1;
                            w_len_add = (r_mode == M_EXP_SIGN) ? 2'd3 : 2'd2;
                            n_psep    = 1'b0;
                            n_pdig    = 1'b1;
                            n_float   = 1'b1;
                            n_pend    = 2'd0;
                            n_mode    = M_EXP;
                        end else begin
                            w_fin        = 1'b1;
                            w_fin_replay = r_pend + 2'd1;
                        end
                    end
                    M_BIN, M_HEX: begin
                        if ((r_mode == M_BIN) ? i_class.is_bin : i_class.is_hex) begin
                            w_len_add = 2'd1;
                            n_psep    = 1'b0;
                            n_pdig    = 1'b1;
                            n_pfx     = 1'b1;
                            w_do_acc  = 1'b1;
                            w_radix   = (r_mode == M_BIN) ? RADIX_BIN : RADIX_HEX;
                        end else if (i_class.is_us) begin
                            if (!n_pdig) n_serr = 1'b1;
                            w_len_add = 2'd1;
                            n_psep    = 1'b1;
                            n_pdig    = 1'b0;
                        end else begin
                            w_fin        = 1'b1;
                            w_fin_replay = 2'd1;
                        end
                    end
                    default: begin
                        // Idle: the first byte opens a literal or is rejected on its own.
                        n_acc      = '0;
                        n_ovf      = 1'b0;
                        n_serr     = 1'b0;
                        n_pfx      = 1'b0;
                        n_float    = 1'b0;
                        n_pend     = 2'd0;
                        n_psep     = 1'b0;
                        w_len_base = '0;
                        if (i_class.is_dec) begin
                            w_len_add = 2'd1;
                            n_pdig    = 1'b1;
                            n_acc     = VALUE_BITS'(i_class.digit);
                            n_mode    = (i_class.digit == 4'd0) ? M_ZERO : M_INT;
                        end else begin
                            n_pdig      = 1'b0;
                            n_mode      = M_IDLE;
                            w_bad_first = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (w_do_acc && !r_ovf) begin
            if (w_prod_ovf) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = w_prod[VALUE_BITS-1:0];
            end
        end

        w_len_sum = (CNT_BITS + 1)'(w_len_base) + (CNT_BITS + 1)'(w_len_add);
        n_len     = w_len_sum[CNT_BITS] ? '1 : w_len_sum[CNT_BITS-1:0];

        if (w_fin || w_bad_first) begin
            n_mode  = M_IDLE;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_serr  = 1'b0;
            n_psep  = 1'b0;
            n_pdig  = 1'b0;
            n_pfx   = 1'b0;
            n_float = 1'b0;
            n_len   = '0;
            n_pend  = 2'd0;
        end
    end

    // A finish never changes the state before it, so the result comes from the registers.
    always_comb begin
        w_sep_bad = r_serr || r_psep;
        w_int_bad = w_sep_bad || r_ovf
                    || (((r_mode == M_BIN) || (r_mode == M_HEX)) && !r_pfx)
                    || (r_len > CNT_BITS'(MAX_INT_SPELLING));
        w_len_out = (r_len > CNT_BITS'(LEN_MAX)) ? LEN_MAX : r_len[LENGTH_BITS-1:0];

        o_emit = w_fin || w_bad_first;
        if (w_bad_first) begin
            o_result.kind   = KIND_BAD;
            o_result.value  = '0;
            o_result.length = LENGTH_BITS'(1);
            o_result.replay = 2'd0;
        end else begin
            o_result.length = w_len_out;
            o_result.replay = w_fin_replay;
            if (r_float) begin
                o_result.kind  = w_sep_bad ? KIND_BAD : KIND_FLOAT;
                o_result.value = '0;
            end else begin
                o_result.kind  = w_int_bad ? KIND_BAD : KIND_INT;
                o_result.value = w_int_bad ? '0 : r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_serr  <= 1'b0;
            r_psep  <= 1'b0;
            r_pdig  <= 1'b0;
            r_pfx   <= 1'b0;
            r_float <= 1'b0;
            r_len   <= '0;
            r_pend  <= 2'd0;
        end else begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_serr  <= n_serr;
            r_psep  <= n_psep;
            r_pdig  <= n_pdig;
            r_pfx   <= n_pfx;
            r_float <= n_float;
            r_len   <= n_len;
            r_pend  <= n_pend;
        end
    end

endmodule

`default_nettype wire

// ----- sv/numeric_literal_scanner_core.sv -----
// Numeric literal scanner core: input register, byte classifier, scanner and result
// register. The input channel carries one source byte per transfer (or an end-of-text
// mark); the output channel carries one result per recognized literal.
// Results: the byte that ends the literal (or the end-of-text mark) passes the input
// register and the scanner, and its result is then held in the result register; bytes
// inside a literal give no result.
// Throughput: one byte per cycle while the result side does not stall; the scanner
// state is updated between the input register and the result register.
// Reset: synchronous and active low; the scanner returns to idle, both registers empty.
// Stall: while a result waits and the receiver holds ready low, the input register holds
// its byte and o_in_ready stays low once it is full; no byte or result is lost.
// Depends on nls_pkg, nls_classify, nls_scan and numeric_literal_scanner_core_assert.svh.
`default_nettype none

module numeric_literal_scanner_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [7:0]                      i_text_byte,
    input  wire logic                            i_end_of_text,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_literal_kind,
    output logic [nls_pkg::VALUE_BITS-1:0]       o_literal_value,
    output logic [nls_pkg::LENGTH_BITS-1:0]      o_literal_length,
    output logic [1:0]                           o_replay_count
);
    import nls_pkg::*;

    `include "numeric_literal_scanner_core_assert.svh"

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eot;
    logic        r_out_valid;
    t_result     r_out_result;

    logic        w_in_xfer;
    logic        w_advance;
    logic        w_emit;
    t_byte_class w_class;
    t_result     w_result;

    // The held byte moves on whenever the result register can take what it may produce.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    nls_classify u_classify (
        .i_byte  (r_in_byte),
        .o_class (w_class)
    );

    nls_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_end_of_text (r_in_eot),
        .i_class       (w_class),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_literal_kind   = r_out_result.kind;
    assign o_literal_value  = r_out_result.value;
    assign o_literal_length = r_out_result.length;
    assign o_replay_count   = r_out_result.replay;

    `NLSC_ASSERT_NEXT(a_stall_holds_input, r_out_valid && !i_out_ready && r_in_valid, r_in_valid && r_out_valid && $stable(r_in_byte) && $stable(r_in_eot), "stalled output did not hold the input register")
    `NLSC_ASSERT_ALWAYS(a_value_only_for_int, !o_out_valid || (o_literal_kind == KIND_INT) || (o_literal_value == '0), "non-integer result carries a value")
    `NLSC_ASSERT_ALWAYS(a_length_nonzero, !o_out_valid || (o_literal_length != '0), "result with zero length")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for numeric_literal_scanner_core: feeds byte streams of
// numeric literals, predicts each result in a scoreboard class and compares them.
// Depends on nls_pkg and the numeric_literal_scanner_core RTL.

module tb;
    import nls_pkg::*;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          RANDOM_BYTES = 1800;
    localparam logic [63:0] VALUE_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } t_feed;

    // Mirrors the scanner state and holds the results still owed by the block.
    class literal_scoreboard;
        t_scan_mode  mode;
        logic [63:0] acc;
        bit          ovf;
        bit          sep_err;
        bit          prev_sep;
        bit          prev_digit;
        bit          prefix_digit;
        bit          is_float;
        int unsigned len_cnt;
        logic [1:0]  pend;
        t_result     pending_literals[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            mode         = M_IDLE;
            acc          = '0;
            ovf          = 0;
            sep_err      = 0;
            prev_sep     = 0;
            prev_digit   = 0;
            prefix_digit = 0;
            is_float     = 0;
            len_cnt      = 0;
            pend         = '0;
        endfunction

        function bit is_dec(logic [7:0] b);
            return b >= CH_0 && b <= CH_9;
        endfunction

        function void bump();
            if (len_cnt != 32'hFFFF_FFFF) len_cnt++;
        endfunction

        function void take_digit();
            bump();
            prev_sep   = 0;
            prev_digit = 1;
        endfunction

        function void take_sep();
            if (!prev_digit) sep_err = 1;
            bump();
            prev_sep   = 1;
            prev_digit = 0;
        endfunction

        function void take_other();
            if (prev_sep) sep_err = 1;
            bump();
            prev_sep   = 0;
            prev_digit = 0;
        endfunction

        function void accumulate(logic [63:0] base, logic [63:0] d);
            if (ovf) return;
            if (acc > (VALUE_MAX - d) / base) ovf = 1;
            else acc = acc * base + d;
        endfunction

        function void emit(logic [1:0] kind, logic [62:0] value, int unsigned n,
                           logic [1:0] replay);
            t_result     r;
            int unsigned len_max;
            len_max  = (32'd1 << LENGTH_BITS) - 1;
            r.kind   = kind;
            r.value  = value;
            r.length = (n > len_max) ? len_max[LENGTH_BITS-1:0] : n[LENGTH_BITS-1:0];
            r.replay = replay;
            pending_literals.push_back(r);
            clear();
        endfunction

        function void finish(logic [1:0] replay);
            bit err;
            err = sep_err || prev_sep;
            if (is_float) begin
                emit(err ? KIND_BAD : KIND_FLOAT, '0, len_cnt, replay);
                return;
            end
            if (ovf) err = 1;
            if ((mode == M_BIN || mode == M_HEX) && !prefix_digit) err = 1;
            if (len_cnt > MAX_INT_SPELLING) err = 1;
            if (err) emit(KIND_BAD, '0, len_cnt, replay);
            else emit(KIND_INT, acc[62:0], len_cnt, replay);
        endfunction

        function void decimal_byte(logic [7:0] b);
            mode = M_INT;
            if (is_dec(b)) begin
                take_digit();
                accumulate(64'd10, 64'(b - CH_0));
            end else if (b == CH_US) begin
                take_sep();
            end else if (b == CH_DOT) begin
                mode = M_DOT;
                pend = 2'd1;
            end else if (b == CH_LE || b == CH_UE) begin
                mode = M_EXP_E;
                pend = 2'd1;
            end else begin
                finish(2'd1);
            end
        endfunction

        // Called for every accepted input transfer.
        function void take_byte(logic [7:0] b, logic eot);
            logic [63:0] hex_digit;
            if (eot) begin
                if (mode != M_IDLE) finish(pend);
                return;
            end
            case (mode)
                M_ZERO: begin
                    if (b == CH_LB) begin
                        take_other();
                        mode = M_BIN;
                    end else if (b == CH_LX) begin
                        take_other();
                        mode = M_HEX;
                    end else begin
                        decimal_byte(b);
                    end
                end
                M_INT: decimal_byte(b);
                M_DOT: begin
                    if (is_dec(b)) begin
                        take_other();
                        take_digit();
                        is_float = 1;
                        pend     = '0;
                        mode     = M_FRAC;
                    end else begin
                        finish(2'd2);
                    end
                end
                M_FRAC, M_EXP: begin
                    if (is_dec(b)) take_digit();
                    else if (b == CH_US) take_sep();
                    else if (mode == M_FRAC && (b == CH_LE || b == CH_UE)) begin
                        mode = M_EXP_E;
                        pend = 2'd1;
                    end else finish(2'd1);
                end
                M_EXP_E, M_EXP_SIGN: begin
                    if (mode == M_EXP_E && (b == CH_PLUS || b == CH_MINUS)) begin
                        mode = M_EXP_SIGN;
                        pend = 2'd2;
                    end else if (is_dec(b)) begin
                        take_other();
                        if (mode == M_EXP_SIGN) take_other();
                        take_digit();
                        is_float = 1;
                        pend     = '0;
                        mode     = M_EXP;
                    end else begin
                        finish(pend + 2'd1);
                    end
                end
                M_BIN: begin
                    if (b == CH_0 || b == CH_1) begin
                        take_digit();
                        prefix_digit = 1;
                        accumulate(64'd2, 64'(b - CH_0));
                    end else if (b == CH_US) take_sep();
                    else finish(2'd1);
                end
                M_HEX: begin
                    if (is_dec(b) || (b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF))
                    begin
                        if (is_dec(b)) hex_digit = 64'(b - CH_0);
                        else if (b >= CH_LA) hex_digit = 64'(b - CH_LA) + 64'd10;
                        else hex_digit = 64'(b - CH_UA) + 64'd10;
                        take_digit();
                        prefix_digit = 1;
                        accumulate(64'd16, hex_digit);
                    end else if (b == CH_US) take_sep();
                    else finish(2'd1);
                end
                default: begin
                    clear();
                    if (!is_dec(b)) begin
                        emit(KIND_BAD, '0, 1, 2'd0);
                    end else begin
                        take_digit();
                        acc  = 64'(b - CH_0);
                        mode = (b == CH_0) ? M_ZERO : M_INT;
                    end
                end
            endcase
        endfunction

        function void compare_field(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        // Called for every accepted result transfer.
        function void check_literal(logic [1:0] kind, logic [62:0] value,
                                    logic [LENGTH_BITS-1:0] length, logic [1:0] replay);
            t_result want;
            if (pending_literals.size() == 0) begin
                errors++;
                $display("%0t: unexpected literal: expected none, actual kind %0d value %0d",
                         $time, kind, value);
                return;
            end
            want = pending_literals.pop_front();
            compare_field("literal_kind", 64'(want.kind), 64'(kind));
            compare_field("literal_value", 64'(want.value), 64'(value));
            compare_field("literal_length", 64'(want.length), 64'(length));
            compare_field("replay_count", 64'(want.replay), 64'(replay));
        endfunction
    endclass

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic [7:0]             text_byte   = '0;
    logic                   end_of_text = 1'b0;
    logic                   out_ready   = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [1:0]             lit_kind;
    logic [VALUE_BITS-1:0]  lit_value;
    logic [LENGTH_BITS-1:0] lit_length;
    logic [1:0]             lit_replay;

    literal_scoreboard sb;
    t_feed             feed_q[$];
    int                idle_pct = 17;
    bit                hold_req = 1'b0;
    int                cycles   = 0;

    numeric_literal_scanner_core u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_text_byte      (text_byte),
        .i_end_of_text    (end_of_text),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_literal_kind   (lit_kind),
        .o_literal_value  (lit_value),
        .o_literal_length (lit_length),
        .o_replay_count   (lit_replay)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    always begin
        @(posedge clk);
        if (hold_req) begin
            hold_req = 1'b0;
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_literal(lit_kind, lit_value, lit_length, lit_replay);
    end

    function automatic void add_byte(logic [7:0] b);
        feed_q.push_back(t_feed'{text: b, eot: 1'b0});
    endfunction

    function automatic void add_eot();
        feed_q.push_back(t_feed'{text: 8'($urandom_range(255)), eot: 1'b1});
    endfunction

    function automatic void add_text(string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    // Digits of the given radix, with an occasional underscore between two of them.
    function automatic void add_digits(int radix, int n);
        string hex_chars;
        hex_chars = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) begin
            case (radix)
                2:       add_byte(CH_0 + 8'($urandom_range(1)));
                10:      add_byte(CH_0 + 8'($urandom_range(9)));
                default: add_byte(hex_chars[$urandom_range(21)]);
            endcase
            if (i < n - 1 && $urandom_range(99) < 15) add_byte(CH_US);
        end
    endfunction

    function automatic void add_terminator();
        string stops;
        int    r;
        stops = " ;,)\n+-";
        r     = $urandom_range(99);
        if (r < 30) add_eot();
        else if (r < 60) add_byte(stops[$urandom_range(stops.len() - 1)]);
        else add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void add_random_literal();
        int r;
        int n;
        r = $urandom_range(99);
        if ($urandom_range(99) == 0) begin
            // Integer spellings around the length bound.
            n = 253 + $urandom_range(4);
            repeat (n) add_byte(CH_0);
            add_terminator();
            return;
        end
        if (r < 18) begin
            if ($urandom_range(19) == 0) add_byte(CH_0);
            else add_byte(CH_1 + 8'($urandom_range(8)));
            add_digits(10, $urandom_range(7));
        end else if (r < 28) begin
            add_text("0b");
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(12);
            add_digits(2, n);
        end else if (r < 38) begin
            add_text("0x");
            n = ($urandom_range(9) == 0) ? $urandom_range(15, 17) : $urandom_range(10);
            add_digits(16, n);
        end else if (r < 56) begin
            add_byte(CH_0 + 8'($urandom_range(9)));
            add_digits(10, $urandom_range(3));
            n = $urandom_range(2);
            if (n != 1) begin
                add_byte(CH_DOT);
                add_digits(10, $urandom_range(1, 4));
            end
            if (n != 0) begin
                add_byte($urandom_range(1) ? CH_LE : CH_UE);
                case ($urandom_range(2))
                    0: add_byte(CH_PLUS);
                    1: add_byte(CH_MINUS);
                    default: ;
                endcase
                add_digits(10, $urandom_range(1, 3));
            end
        end else if (r < 62) begin
            case ($urandom_range(6))
                0: add_text("9223372036854775807");
                1: add_text("9223372036854775808");
                2: add_text("0x7fffffffffffffff");
                3: add_text("0x8000000000000000");
                4: begin
                    add_text("0b");
                    repeat (63) add_byte(CH_1);
                end
                5: begin
                    add_text("0b1");
                    repeat (63) add_byte(CH_0);
                end
                default: add_text("18446744073709551616");
            endcase
        end else if (r < 76) begin
            // Malformed shapes: dangling dot, exponent or sign, bad underscores, caps, a bad binary digit.
            case ($urandom_range(9))
                0: add_text("4.");
                1: add_text("5e");
                2: add_text("6E-");
                3: add_text("0B");
                4: add_text("0X");
                5: add_text("8_");
                6: add_text("1__2");
                7: add_text("0x_a");
                8: add_text("1.5_e3");
                default: add_text("0b2");
            endcase
        end else if (r < 88) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
            return;
        end else begin
            add_eot();
            return;
        end
        add_terminator();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        do @(posedge clk); while (!in_ready);
        sb.take_byte(b, eot);
    endtask

    task automatic play_feed();
        t_feed f;
        while (feed_q.size() != 0) begin
            f = feed_q.pop_front();
            send_byte(f.text, f.eot);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_literals.size() != 0);
    endtask

    initial begin
        int  fed;
        bit  held;
        bit  drained;
        sb        = new();
        fed       = 0;
        held      = 0;
        drained   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_eot();
        add_byte(8'hFF);
        add_text("7");
        add_eot();
        add_text("0b");
        add_eot();
        add_text("1.e");
        add_text("2e+;");
        add_text("3_");
        add_eot();
        add_text("0X");
        add_text("1.5E-2");
        add_eot();
        add_text("0xF_a ");
        play_feed();
        drain_results();

        while (fed < RANDOM_BYTES) begin
            idle_pct = (fed >= 300 && fed < 600) ? 0 : 17;
            if (fed >= 800 && !held) begin
                held     = 1;
                hold_req = 1'b1;
            end
            if (fed >= 1100 && !drained) begin
                drained = 1;
                drain_results();
            end
            add_random_literal();
            fed += feed_q.size();
            play_feed();
        end
        add_eot();
        play_feed();

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
